// ===== hdl/aes128_block_encrypt_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, round constants and the byte-level round functions.
// ----------------------------------------------------------------------------
package aes_pkg;
	localparam int unsigned NumRounds = 10;
	localparam int unsigned DataW = 128;
	localparam int unsigned HalfW = 64;
	localparam int unsigned CfgIdxW = 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_UPPER = 1'b0,
		REG_KEY_LOWER = 1'b1
	} cfg_reg_t;

	typedef logic [DataW-1:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		case (rnd)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits at bits [127-8i -: 8].
	function automatic logic [7:0] get_byte(input block_t v, input int i);
		return v[DataW-1-8*i -: 8];
	endfunction

	function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
		logic [7:0] b [16];
		block_t r;
		for (int i = 0; i < 16; i++) b[i] = get_byte(k, i);
		b[0] = b[0] ^ rcon(rnd) ^ sbox(b[13]);
		b[1] = b[1] ^ sbox(b[14]);
		b[2] = b[2] ^ sbox(b[15]);
		b[3] = b[3] ^ sbox(b[12]);
		for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
		for (int i = 0; i < 16; i++) r[DataW-1-8*i -: 8] = b[i];
		return r;
	endfunction

	function automatic block_t round_fn(input block_t s, input block_t k, input logic last);
		logic [7:0] a [16];
		logic [7:0] t [16];
		logic [7:0] all;
		block_t r;
		for (int i = 0; i < 16; i++) a[i] = get_byte(s, i);
		for (int c = 0; c < 4; c++)
			for (int rw = 0; rw < 4; rw++)
				t[4*c+rw] = sbox(a[4*((c+rw)%4)+rw]);
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
				a[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
				a[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
				a[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
				a[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
			end
		end else begin
			for (int i = 0; i < 16; i++) a[i] = t[i];
		end
		for (int i = 0; i < 16; i++) r[DataW-1-8*i -: 8] = a[i];
		return r ^ k;
	endfunction
endpackage

// ===== hdl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One cipher round and one key expansion step between two pipeline registers.
// ----------------------------------------------------------------------------
module aes_round #(
	parameter int unsigned Rnd = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  aes_pkg::block_t  state_in,
	input  aes_pkg::block_t  key_in,
	output logic             vld_s1,
	output aes_pkg::block_t  state_s1,
	output aes_pkg::block_t  key_s1
);
	import aes_pkg::*;

	block_t rkey;

	assign rkey = next_key(key_in, 4'(Rnd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_s1   <= rkey;
			state_s1 <= round_fn(state_in, rkey, Rnd == NumRounds - 1);
		end
	end
endmodule

// ===== hdl/aes128_block_encrypt_top.sv =====
// Throughput: one 128-bit block per cycle while the output is not stalled; one register stage per cipher round.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
// AES-128 encryption pipeline
// Key registers, registered initial key addition and ten round stages; the last drives the output.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_idx,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // plain_upper [63:0], plain_lower [127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // cipher_upper [63:0], cipher_lower [127:64]
);
	import aes_pkg::*;

	logic [HalfW-1:0] key_upper_q, key_lower_q;
	logic             vld_s0;
	block_t           state_s0, key_s0;
	logic             vld   [NumRounds+1];
	block_t           st    [NumRounds+1];
	block_t           ky    [NumRounds+1];
	logic             en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it holds only when the output is stalled.
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s0 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
				^ {key_upper_q, key_lower_q};
			key_s0 <= {key_upper_q, key_lower_q};
		end
	end

	assign vld[0] = vld_s0;
	assign st[0]  = state_s0;
	assign ky[0]  = key_s0;

	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		aes_round #(.Rnd(r)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld[r]),
			.state_in (st[r]),
			.key_in   (ky[r]),
			.vld_s1   (vld[r+1]),
			.state_s1 (st[r+1]),
			.key_s1   (ky[r+1])
		);
	end

	assign m_axis_tvalid = vld[NumRounds];
	assign m_axis_tdata  = {st[NumRounds][HalfW-1:0], st[NumRounds][DataW-1:HalfW]};
endmodule

// ===== hdl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// AES port checker
// Watches the stream ports of the encryption pipeline.
// ----------------------------------------------------------------------------
`include "aes128_block_encrypt_top_assert.svh"
module aes_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	// A stalled result keeps its data.
	`AES_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// Input is taken exactly when the output is free to move.
	`AES_ASSERT_IMPL(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
	// A stalled output also stalls the input side.
	`AES_ASSERT_IMPL(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind aes128_block_encrypt_top aes_checker u_aes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
